>>> rtl/core/rrts_pkg.sv
// shared types, constants and helpers for the round-robin task scheduler
// no dependencies; used by the channel interfaces and the core
package rrts_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int SLICE_W     = 17;
   localparam int RELOAD_W    = 16;
   localparam int CMD_W       = 3;
   localparam int ERR_W       = 2;
   localparam int COUNT_W     = 5;

   localparam logic [RELOAD_W-1:0] RELOAD_RESET = RELOAD_W'(10);
   localparam logic signed [SLICE_W-1:0] SLICE_MIN = {1'b1, {(SLICE_W-1){1'b0}}};

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE     = 3'd0,
      CMD_REMOVE      = 3'd1,
      CMD_TICK        = 3'd2,
      CMD_MAYBE_SCHED = 3'd3,
      CMD_SCHEDULE    = 3'd4
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_FULL      = 2'd1,
      ERR_NOT_FOUND = 2'd2,
      ERR_EMPTY     = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MODIFY,
      ST_WALK,
      ST_FETCH,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [SLICE_W-1:0] slice;
   } entry_type;

   // circular index arithmetic: base + off wrapped into the queue depth
   function automatic idx_type idx_add(idx_type base, cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> rtl/core/rrts_if.sv
// valid/ready channel interfaces for the scheduler command and result items
// depends on rrts_pkg for field widths
interface rrts_req_if;
   logic                       valid;
   logic                       ready;
   logic [rrts_pkg::CMD_W-1:0] cmd;
   logic [rrts_pkg::ID_W-1:0]  task_id;

   modport source (output valid, output cmd, output task_id, input ready);
   modport sink   (input valid, input cmd, input task_id, output ready);
endinterface

interface rrts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrts_pkg::ID_W-1:0]    running_id;
   logic [rrts_pkg::COUNT_W-1:0] queue_count;
   logic                         switched;
   logic [rrts_pkg::ERR_W-1:0]   error;

   modport source (output valid, output running_id, output queue_count,
                   output switched, output error, input ready);
   modport sink   (input valid, input running_id, input queue_count,
                   input switched, input error, output ready);
endinterface

>>> rtl/core/round_robin_task_scheduler_core.sv
// round-robin run queue with per-task time slice, one command item at a time
// depends on rrts_pkg and the channel interfaces in rrts_if.sv
//
// usage:
//   req_ch carries one command item (cmd, task_id); rsp_ch returns exactly one
//   result item (running_id, queue_count, switched, error) per command.
//   csr_wr_en/csr_wr_data write the slice reload value; the user must do so
//   only while the block is idle, which the block itself does not enforce.
// sequence: decode; then, on a non-empty queue, modify (tick, schedule, or a
//   rescheduling maybe-schedule) or walk (remove); then fetch and load.
//   the queue lives in a single-port-read, single-port-write memory with a
//   registered read, so the sequencer walks it one entry per cycle.
// handshake: one item in flight; req_ch.ready is high only while the
//   sequencer is idle, so a new item is taken only after the last one's
//   result is loaded; the next item may be taken while a result still waits.
// reset: queue empty, reschedule flag clear, slice reload 10; no clearing
//   pass, as only entries below the fill count are ever reported.
// stall: when rsp_ch.ready is low the result register holds, and the
//   sequencer waits in its last step with the next result until it drains.
module round_robin_task_scheduler_core (
   input  logic                           clock,
   input  logic                           reset,
   rrts_req_if.sink                       req_ch,
   rrts_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [rrts_pkg::RELOAD_W-1:0]  csr_wr_data
);

   rrts_pkg::state_type state_ff, state_in;
   rrts_pkg::idx_type   head_ff, head_in;
   rrts_pkg::cnt_type   len_ff, len_in;
   rrts_pkg::idx_type   rd_ptr_ff, rd_ptr_in;
   rrts_pkg::idx_type   wr_ptr_ff, wr_ptr_in;
   rrts_pkg::cnt_type   k_ff, k_in;
   rrts_pkg::cnt_type   w_ff, w_in;
   logic                resched_ff, resched_in;
   logic [rrts_pkg::RELOAD_W-1:0] reload_ff;
   logic [rrts_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [rrts_pkg::ID_W-1:0]     id_ff, id_in;
   rrts_pkg::err_type   err_ff, err_in;
   logic                sw_ff, sw_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [rrts_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                rsp_sw_ff, rsp_sw_in;
   rrts_pkg::err_type   rsp_err_ff, rsp_err_in;

   rrts_pkg::entry_type mem [rrts_pkg::QUEUE_DEPTH];
   rrts_pkg::entry_type rd_data_ff;
   logic                rd_en;
   rrts_pkg::idx_type   rd_addr;
   logic                wr_en;
   rrts_pkg::idx_type   wr_addr;
   rrts_pkg::entry_type wr_data;

   logic                req_fire;
   logic                out_free;
   logic                is_empty;
   logic                is_full;
   logic                keep;
   rrts_pkg::cnt_type   w_next;
   rrts_pkg::idx_type   tail;
   logic signed [rrts_pkg::SLICE_W-1:0] slice_dec;
   logic signed [rrts_pkg::SLICE_W-1:0] slice_reload;

   assign req_ch.ready = (state_ff == rrts_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_empty     = (len_ff == '0);
   assign is_full      = (len_ff == rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH));
   assign keep         = (rd_data_ff.id != id_ff);
   assign w_next       = keep ? w_ff + rrts_pkg::CNT_W'(1) : w_ff;
   assign tail         = rrts_pkg::idx_add(head_ff, len_ff);
   assign slice_reload = rrts_pkg::SLICE_W'({1'b0, reload_ff});
   // saturating decrement at the most negative slice
   assign slice_dec    = (rd_data_ff.slice == rrts_pkg::SLICE_MIN) ?
                         rrts_pkg::SLICE_MIN :
                         rd_data_ff.slice - rrts_pkg::SLICE_W'(1);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.running_id  = rsp_id_ff;
   assign rsp_ch.queue_count = rsp_count_ff;
   assign rsp_ch.switched    = rsp_sw_ff;
   assign rsp_ch.error       = rsp_err_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = rrts_pkg::ST_DECODE;
            end
         end
         rrts_pkg::ST_DECODE: begin
            state_in = rrts_pkg::ST_FETCH;
            unique case (cmd_ff) inside
               rrts_pkg::CMD_REMOVE: begin
                  if (!is_empty) begin
                     state_in = rrts_pkg::ST_WALK;
                  end
               end
               rrts_pkg::CMD_TICK, rrts_pkg::CMD_SCHEDULE: begin
                  if (!is_empty) begin
                     state_in = rrts_pkg::ST_MODIFY;
                  end
               end
               rrts_pkg::CMD_MAYBE_SCHED: begin
                  if (resched_ff && !is_empty) begin
                     state_in = rrts_pkg::ST_MODIFY;
                  end
               end
               default: begin
                  state_in = rrts_pkg::ST_FETCH;
               end
            endcase
         end
         rrts_pkg::ST_MODIFY: begin
            state_in = rrts_pkg::ST_FETCH;
         end
         rrts_pkg::ST_WALK: begin
            if (k_ff == len_ff) begin
               state_in = rrts_pkg::ST_FETCH;
            end
         end
         rrts_pkg::ST_FETCH: begin
            state_in = rrts_pkg::ST_LOAD;
         end
         rrts_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = rrts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      head_in      = head_ff;
      len_in       = len_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      resched_in   = resched_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      err_in       = err_ff;
      sw_in        = sw_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = tail;
      wr_data      = rd_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in = req_ch.cmd;
               id_in  = req_ch.task_id;
               err_in = rrts_pkg::ERR_OK;
               sw_in  = 1'b0;
            end
         end
         rrts_pkg::ST_DECODE: begin
            unique case (cmd_ff) inside
               rrts_pkg::CMD_ENQUEUE: begin
                  if (is_full) begin
                     err_in = rrts_pkg::ERR_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = tail;
                     wr_data = '{id: id_ff, slice: slice_reload};
                     len_in  = len_ff + rrts_pkg::CNT_W'(1);
                  end
               end
               rrts_pkg::CMD_REMOVE: begin
                  if (is_empty) begin
                     err_in = rrts_pkg::ERR_NOT_FOUND;
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr   = head_ff;
                     rd_ptr_in = rrts_pkg::idx_add(head_ff, rrts_pkg::CNT_W'(1));
                     wr_ptr_in = head_ff;
                     k_in      = rrts_pkg::CNT_W'(1);
                     w_in      = '0;
                  end
               end
               rrts_pkg::CMD_TICK, rrts_pkg::CMD_SCHEDULE: begin
                  if (is_empty) begin
                     err_in = rrts_pkg::ERR_EMPTY;
                  end else begin
                     rd_en = 1'b1;
                  end
               end
               rrts_pkg::CMD_MAYBE_SCHED: begin
                  if (resched_ff) begin
                     resched_in = 1'b0;
                     if (is_empty) begin
                        err_in = rrts_pkg::ERR_EMPTY;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
               end
               default: begin
                  err_in = rrts_pkg::ERR_OK;
               end
            endcase
         end
         rrts_pkg::ST_MODIFY: begin
            if (cmd_ff == rrts_pkg::CMD_TICK) begin
               wr_en   = 1'b1;
               wr_addr = head_ff;
               wr_data = '{id: rd_data_ff.id, slice: slice_dec};
               if (slice_dec <= 0) begin
                  resched_in = 1'b1;
               end
            end else begin
               // rotation: copy the front entry to the tail slot, advance head
               wr_en   = 1'b1;
               wr_addr = tail;
               if (cmd_ff == rrts_pkg::CMD_MAYBE_SCHED) begin
                  wr_data = '{id: rd_data_ff.id, slice: slice_reload};
               end
               head_in = rrts_pkg::idx_add(head_ff, rrts_pkg::CNT_W'(1));
               sw_in   = 1'b1;
            end
         end
         rrts_pkg::ST_WALK: begin
            // rd_data_ff holds entry k-1; survivors are packed toward head
            if (keep) begin
               wr_en     = 1'b1;
               wr_addr   = wr_ptr_ff;
               wr_ptr_in = rrts_pkg::idx_add(wr_ptr_ff, rrts_pkg::CNT_W'(1));
            end
            w_in = w_next;
            if (k_ff != len_ff) begin
               rd_en     = 1'b1;
               rd_addr   = rd_ptr_ff;
               rd_ptr_in = rrts_pkg::idx_add(rd_ptr_ff, rrts_pkg::CNT_W'(1));
               k_in      = k_ff + rrts_pkg::CNT_W'(1);
            end else begin
               len_in = w_next;
               if (w_next == len_ff) begin
                  err_in = rrts_pkg::ERR_NOT_FOUND;
               end
            end
         end
         rrts_pkg::ST_FETCH: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         rrts_pkg::ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = is_empty ? '0 : rd_data_ff.id;
               rsp_count_in = rrts_pkg::COUNT_W'(len_ff);
               rsp_sw_in    = sw_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_IDLE;
         head_ff      <= '0;
         len_ff       <= '0;
         resched_ff   <= 1'b0;
         reload_ff    <= rrts_pkg::RELOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         resched_ff   <= resched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            reload_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      err_ff       <= err_in;
      sw_ff        <= sw_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH))
      else $error("queue length beyond depth");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::ST_WALK) |-> (k_ff <= len_ff && w_ff < k_ff))
      else $error("remove walk counters out of order");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == rrts_pkg::ST_DECODE))
      else $error("accepted item not decoded");

   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sw_ff) |->
         (rsp_err_ff == rrts_pkg::ERR_OK && rsp_count_ff != '0))
      else $error("switch reported with error or empty queue");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff == rrts_pkg::ERR_FULL) |->
         (rsp_count_ff == rrts_pkg::COUNT_W'(rrts_pkg::QUEUE_DEPTH)))
      else $error("full error without a full queue");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for round_robin_task_scheduler_core: directed and random command items,
// each result item checked against an in-bench run queue predictor
// depends on rrts_pkg, rrts_if.sv and the core rtl
module tb_top;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = rrts_pkg::QUEUE_DEPTH + 8;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 140;
   localparam int DEEP_TICKS      = 40;
   localparam int RSP_HOLD_CYCLES = 300;

   localparam logic [rrts_pkg::CMD_W-1:0] CMD_UNKNOWN_FIRST = rrts_pkg::CMD_SCHEDULE + 3'd1;
   localparam logic [rrts_pkg::CMD_W-1:0] CMD_UNKNOWN_LAST  = '1;

   typedef struct {
      logic [rrts_pkg::ID_W-1:0]    running_id;
      logic [rrts_pkg::COUNT_W-1:0] queue_count;
      logic                         switched;
      rrts_pkg::err_type            error;
   } sched_report_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [rrts_pkg::RELOAD_W-1:0] csr_wr_data;

   rrts_req_if req_ch ();
   rrts_rsp_if rsp_ch ();

   round_robin_task_scheduler_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted run queue
   logic [rrts_pkg::ID_W-1:0]           rq_ids    [rrts_pkg::QUEUE_DEPTH];
   logic signed [rrts_pkg::SLICE_W-1:0] rq_slices [rrts_pkg::QUEUE_DEPTH];
   int unsigned                         rq_len     = 0;
   bit                                  rq_resched = 1'b0;
   logic [rrts_pkg::RELOAD_W-1:0]       rq_reload  = rrts_pkg::RELOAD_RESET;

   sched_report_type step_reports [$];

   int idle_pct      = 28;
   int hold_request  = 0;
   int hold_left     = 0;
   int stall_cycles  = 0;
   int fail_count    = 0;
   int item_count    = 0;
   int report_count  = 0;
   int reload_writes = 0;
   int switch_count  = 0;
   int full_count    = 0;
   int missing_count = 0;
   int empty_count   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void rotate_run_queue(inout sched_report_type rep);
      logic [rrts_pkg::ID_W-1:0]           head_id;
      logic signed [rrts_pkg::SLICE_W-1:0] head_slice;
      if (rq_len == 0) begin
         rep.error = rrts_pkg::ERR_EMPTY;
      end else begin
         if (rq_len > 1) begin
            head_id    = rq_ids[0];
            head_slice = rq_slices[0];
            for (int k = 0; k + 1 < rq_len; k++) begin
               rq_ids[k]    = rq_ids[k+1];
               rq_slices[k] = rq_slices[k+1];
            end
            rq_ids[rq_len-1]    = head_id;
            rq_slices[rq_len-1] = head_slice;
         end
         rep.switched = 1'b1;
      end
   endfunction

   function automatic sched_report_type run_queue_step(
         input logic [rrts_pkg::CMD_W-1:0] c,
         input logic [rrts_pkg::ID_W-1:0]  id);
      sched_report_type rep;
      int unsigned      w;
      rep.switched = 1'b0;
      rep.error    = rrts_pkg::ERR_OK;
      case (c)
         rrts_pkg::CMD_ENQUEUE: begin
            if (rq_len >= rrts_pkg::QUEUE_DEPTH) begin
               rep.error = rrts_pkg::ERR_FULL;
            end else begin
               rq_ids[rq_len]    = id;
               rq_slices[rq_len] = $signed({1'b0, rq_reload});
               rq_len++;
            end
         end
         rrts_pkg::CMD_REMOVE: begin
            // compact in place, dropping every entry that holds the id
            w = 0;
            for (int k = 0; k < rq_len; k++) begin
               if (rq_ids[k] != id) begin
                  rq_ids[w]    = rq_ids[k];
                  rq_slices[w] = rq_slices[k];
                  w++;
               end
            end
            if (w == rq_len) begin
               rep.error = rrts_pkg::ERR_NOT_FOUND;
            end
            rq_len = w;
         end
         rrts_pkg::CMD_TICK: begin
            if (rq_len == 0) begin
               rep.error = rrts_pkg::ERR_EMPTY;
            end else begin
               if (rq_slices[0] != rrts_pkg::SLICE_MIN) begin
                  rq_slices[0] = rq_slices[0] - 17'sd1;
               end
               if (rq_slices[0] <= 17'sd0) begin
                  rq_resched = 1'b1;
               end
            end
         end
         rrts_pkg::CMD_MAYBE_SCHED: begin
            if (rq_resched) begin
               rq_resched = 1'b0;
               if (rq_len == 0) begin
                  rep.error = rrts_pkg::ERR_EMPTY;
               end else begin
                  rq_slices[0] = $signed({1'b0, rq_reload});
                  rotate_run_queue(rep);
               end
            end
         end
         rrts_pkg::CMD_SCHEDULE: begin
            rotate_run_queue(rep);
         end
         default: begin
         end
      endcase
      rep.running_id  = (rq_len > 0) ? rq_ids[0] : '0;
      rep.queue_count = rrts_pkg::COUNT_W'(rq_len);
      return rep;
   endfunction

   task automatic send_item(input logic [rrts_pkg::CMD_W-1:0] c,
                            input logic [rrts_pkg::ID_W-1:0]  id);
      sched_report_type rep;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= c;
      req_ch.task_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      rep = run_queue_step(c, id);
      step_reports.insert(step_reports.size(), rep);
      item_count++;
      if (rep.switched) begin
         switch_count++;
      end
      case (rep.error)
         rrts_pkg::ERR_FULL:      full_count++;
         rrts_pkg::ERR_NOT_FOUND: missing_count++;
         rrts_pkg::ERR_EMPTY:     empty_count++;
         default: begin
         end
      endcase
   endtask

   task automatic wait_settle();
      req_ch.valid <= 1'b0;
      while (step_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rrts_pkg::RELOAD_W-1:0] value);
      wait_settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rq_reload = value;
      reload_writes++;
   endtask

   task automatic clear_queue();
      while (rq_len > 0) begin
         send_item(rrts_pkg::CMD_REMOVE, rq_ids[0]);
      end
   endtask

   // empty-queue faults, duplicates, rotation, reschedule on a drained queue
   task automatic test_directed();
      csr_write(rrts_pkg::RELOAD_W'(1));
      send_item(rrts_pkg::CMD_SCHEDULE, 8'h00);
      send_item(rrts_pkg::CMD_TICK, 8'hFF);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_REMOVE, 8'h00);
      send_item(CMD_UNKNOWN_FIRST, 8'h12);
      send_item(CMD_UNKNOWN_LAST, 8'hED);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h00);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'hFF);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h00);
      send_item(rrts_pkg::CMD_SCHEDULE, 8'h00);
      send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_REMOVE, 8'h00);
      send_item(rrts_pkg::CMD_REMOVE, 8'h42);
      send_item(rrts_pkg::CMD_SCHEDULE, 8'h00);
      send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_REMOVE, 8'hFF);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h5A);
      send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
   endtask

   task automatic test_reload_range();
      csr_write('1);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h11);
      repeat (3) send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h22);
      send_item(rrts_pkg::CMD_SCHEDULE, 8'h00);
      csr_write(rrts_pkg::RELOAD_W'(2));
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h33);
      repeat (3) send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
   endtask

   // receiver holds off while commands keep coming, so the input stalls
   task automatic test_backpressure();
      hold_request = RSP_HOLD_CYCLES;
      repeat (24) begin
         send_item(rrts_pkg::CMD_W'($urandom_range(rrts_pkg::CMD_SCHEDULE)),
                   rrts_pkg::ID_W'($urandom_range(7)));
      end
   endtask

   // run the front slice far below zero, then bring the task back to the
   // front without a reload and check that it still gets preempted
   task automatic test_deep_slice();
      clear_queue();
      csr_write(rrts_pkg::RELOAD_W'(1));
      idle_pct = 0;
      send_item(rrts_pkg::CMD_ENQUEUE, 8'hC3);
      send_item(rrts_pkg::CMD_ENQUEUE, 8'h3C);
      repeat (DEEP_TICKS) send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_SCHEDULE, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      send_item(rrts_pkg::CMD_TICK, 8'h00);
      send_item(rrts_pkg::CMD_MAYBE_SCHED, 8'h00);
      idle_pct = 28;
   endtask

   task automatic test_random();
      int                            r;
      int                            enq_w;
      int                            rem_w;
      int                            tick_w;
      int                            maybe_w;
      int                            sched_w;
      logic [rrts_pkg::CMD_W-1:0]    c;
      logic [rrts_pkg::ID_W-1:0]     id;
      logic [rrts_pkg::RELOAD_W-1:0] reload;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       reload = rrts_pkg::RELOAD_W'(1);
            1:       reload = '1;
            2:       reload = rrts_pkg::RELOAD_W'(2);
            default: begin
               if ($urandom_range(3) == 0) begin
                  reload = rrts_pkg::RELOAD_W'($urandom_range(1, 65535));
               end else begin
                  reload = rrts_pkg::RELOAD_W'($urandom_range(1, 6));
               end
            end
         endcase
         csr_write(reload);
         // fill, mixed and drain flavors keep the queue moving between empty and full
         case (p % 3)
            0: begin
               enq_w = 40; rem_w = 10; tick_w = 28; maybe_w = 12; sched_w = 8;
            end
            1: begin
               enq_w = 22; rem_w = 22; tick_w = 28; maybe_w = 14; sched_w = 10;
            end
            default: begin
               enq_w = 12; rem_w = 40; tick_w = 26; maybe_w = 12; sched_w = 8;
            end
         endcase
         idle_pct = (p == 4) ? 0 : 28;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r  = $urandom_range(99);
            id = rrts_pkg::ID_W'($urandom_range(255));
            if (r < enq_w) begin
               c = rrts_pkg::CMD_ENQUEUE;
               if ($urandom_range(3) != 0) begin
                  id = rrts_pkg::ID_W'($urandom_range(11));
               end
            end else if (r < enq_w + rem_w) begin
               c = rrts_pkg::CMD_REMOVE;
               if (rq_len > 0 && $urandom_range(9) < 7) begin
                  id = rq_ids[$urandom_range(rq_len - 1)];
               end else if ($urandom_range(1) == 0) begin
                  id = rrts_pkg::ID_W'($urandom_range(11));
               end
            end else if (r < enq_w + rem_w + tick_w) begin
               c = rrts_pkg::CMD_TICK;
            end else if (r < enq_w + rem_w + tick_w + maybe_w) begin
               c = rrts_pkg::CMD_MAYBE_SCHED;
            end else if (r < enq_w + rem_w + tick_w + maybe_w + sched_w) begin
               c = rrts_pkg::CMD_SCHEDULE;
            end else begin
               c = rrts_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
            end
            send_item(c, id);
         end
      end
      idle_pct = 28;
   endtask

   // result side: ready with random idling and one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      sched_report_type want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[round_robin_task_scheduler_core] ERROR");
            $finish;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (step_reports.size() == 0) begin
               $error("result item with no command pending: running_id %0d queue_count %0d",
                      rsp_ch.running_id, rsp_ch.queue_count);
               fail_count++;
            end else begin
               want = step_reports[0];
               step_reports.delete(0);
               report_count++;
               if (rsp_ch.running_id !== want.running_id) begin
                  $error("running_id: expected %0d, got %0d", want.running_id,
                         rsp_ch.running_id);
                  fail_count++;
               end
               if (rsp_ch.queue_count !== want.queue_count) begin
                  $error("queue_count: expected %0d, got %0d", want.queue_count,
                         rsp_ch.queue_count);
                  fail_count++;
               end
               if (rsp_ch.switched !== want.switched) begin
                  $error("switched: expected %0d, got %0d", want.switched, rsp_ch.switched);
                  fail_count++;
               end
               if (rsp_ch.error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_ch.error);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = '0;
      req_ch.task_id = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_reload_range();
      test_backpressure();
      test_deep_slice();
      test_random();
      wait_settle();
      if (step_reports.size() != 0) begin
         $error("%0d result items never arrived", step_reports.size());
         fail_count++;
      end
      $display("covered %0d command items and %0d result items over %0d slice reload writes",
               item_count, report_count, reload_writes);
      $display("outcomes: %0d switches, %0d full, %0d id not found, %0d empty queue",
               switch_count, full_count, missing_count, empty_count);
      if (fail_count == 0) begin
         $display("[round_robin_task_scheduler_core] OK");
      end else begin
         $display("[round_robin_task_scheduler_core] ERROR");
      end
      $finish;
   end

endmodule
